// ===== design/csvs_pkg.sv =====
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared types, character codes and helpers for the CSV field splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] KIND_SPACE = 2'd0;
  localparam logic [1:0] KIND_TAB   = 2'd1;
  localparam logic [1:0] KIND_CR    = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_EMIT,
    ACT_FIELD_END,
    ACT_REC_END
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLAY,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic accept;
    logic replay_emit;
    logic final_emit;
  } csvs_cmd_t;

  typedef struct packed {
    act_e act;
    logic cnt_zero;
    logic replay_done;
    logic out_free;
  } csvs_sts_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic [1:0] ws_kind(input logic [7:0] c);
    logic [1:0] k;
    k = KIND_SPACE;
    if (c == CH_TAB) begin
      k = KIND_TAB;
    end else if (c == CH_CR) begin
      k = KIND_CR;
    end
    return k;
  endfunction

  function automatic logic [7:0] kind_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      KIND_TAB: c = CH_TAB;
      KIND_CR:  c = CH_CR;
      default:  c = CH_SPACE;
    endcase
    return c;
  endfunction

endpackage

// ===== design/csvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// csvs_ctrl
// Sequencer: accepts a beat, replays held whitespace, then emits the byte.
// ----------------------------------------------------------------------------
module csvs_ctrl
  import csvs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  csvs_sts_t sts_i,
  output csvs_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (sts_i.act == ACT_EMIT && !sts_i.cnt_zero) begin
            state_d = ST_REPLAY;
          end
        end
      end
      ST_REPLAY: begin
        if (sts_i.out_free) begin
          cmd_o.replay_emit = 1'b1;
          if (sts_i.replay_done) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.final_emit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/csvs_dp.sv =====
// ----------------------------------------------------------------------------
// csvs_dp
// Datapath: quote/field flags, whitespace buffer, result register.
// ----------------------------------------------------------------------------
module csvs_dp
  import csvs_pkg::*;
#(
  parameter int MaxPend = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_i,
  input  logic [7:0] data_byte_i,
  input  csvs_cmd_t  cmd_in_i,
  output csvs_sts_t  sts_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       field_end_o,
  output logic       record_end_o,
  output logic       ws_overflow_o,
  output logic       last_o
);

  localparam int CntW = $clog2(MaxPend + 1);
  localparam int IdxW = (MaxPend > 1) ? $clog2(MaxPend) : 1;

  logic            in_quotes_q, quote_pend_q, started_q, sticky_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] idx_q;
  logic [7:0]      hold_q;
  logic [1:0]      kinds_mem [MaxPend];
  logic [1:0]      rd_data_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;

  logic       out_valid_q, bv_q, fe_q, re_q, ov_q, last_q;
  logic [7:0] byte_q;

  act_e act;
  logic iq_n, qp_n, unq;
  logic [IdxW-1:0] last_idx;

  function automatic act_e content_act(input logic [7:0] c, input logic started);
    act_e a;
    if (is_ws(c)) begin
      a = started ? ACT_PUSH : ACT_NONE;
    end else begin
      a = ACT_EMIT;
    end
    return a;
  endfunction

  always_comb begin
    act  = ACT_NONE;
    iq_n = in_quotes_q;
    qp_n = quote_pend_q;
    unq  = 1'b0;
    if (cmd_i) begin
      act  = ACT_REC_END;
      iq_n = 1'b0;
      qp_n = 1'b0;
    end else if (quote_pend_q) begin
      qp_n = 1'b0;
      if (data_byte_i == CH_QUOTE) begin
        act = content_act(data_byte_i, started_q);
      end else begin
        iq_n = 1'b0;
        unq  = 1'b1;
      end
    end else if (in_quotes_q) begin
      if (data_byte_i == CH_QUOTE) begin
        qp_n = 1'b1;
      end else begin
        act = content_act(data_byte_i, started_q);
      end
    end else begin
      unq = 1'b1;
    end
    if (unq) begin
      if (data_byte_i == CH_QUOTE) begin
        iq_n = 1'b1;
      end else if (data_byte_i == CH_COMMA) begin
        act = ACT_FIELD_END;
      end else begin
        act = content_act(data_byte_i, started_q);
      end
    end
  end

  assign last_idx = IdxW'(cnt_q - 1'b1);

  assign sts_o.act         = act;
  assign sts_o.cnt_zero    = (cnt_q == '0);
  assign sts_o.replay_done = (idx_q == last_idx);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_in_i.accept && act == ACT_EMIT) begin
      rd_en = 1'b1;
    end else if (cmd_in_i.replay_emit && !sts_o.replay_done) begin
      rd_en   = 1'b1;
      rd_addr = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.accept && act == ACT_PUSH && cnt_q < CntW'(MaxPend)) begin
      kinds_mem[cnt_q[IdxW-1:0]] <= ws_kind(data_byte_i);
    end
    if (rd_en) begin
      rd_data_q <= kinds_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q  <= 1'b0;
      quote_pend_q <= 1'b0;
      started_q    <= 1'b0;
      sticky_q     <= 1'b0;
      cnt_q        <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_in_i.accept) begin
        in_quotes_q  <= iq_n;
        quote_pend_q <= qp_n;
        case (act)
          ACT_PUSH: begin
            if (cnt_q < CntW'(MaxPend)) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              sticky_q <= 1'b1;
            end
          end
          ACT_EMIT: begin
            started_q <= 1'b1;
            idx_q     <= '0;
            if (cnt_q == '0) begin
              out_valid_q <= 1'b1;
            end
          end
          ACT_FIELD_END, ACT_REC_END: begin
            out_valid_q <= 1'b1;
            started_q   <= 1'b0;
            sticky_q    <= 1'b0;
            cnt_q       <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_in_i.replay_emit) begin
        out_valid_q <= 1'b1;
        if (!sts_o.replay_done) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (cmd_in_i.final_emit) begin
        out_valid_q <= 1'b1;
        cnt_q       <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.accept) begin
      hold_q <= data_byte_i;
      byte_q <= data_byte_i;
      bv_q   <= 1'b1;
      fe_q   <= 1'b0;
      re_q   <= 1'b0;
      ov_q   <= 1'b0;
      last_q <= 1'b1;
      if (act == ACT_FIELD_END || act == ACT_REC_END) begin
        byte_q <= '0;
        bv_q   <= 1'b0;
        fe_q   <= 1'b1;
        re_q   <= (act == ACT_REC_END);
        ov_q   <= sticky_q;
      end
    end
    if (cmd_in_i.replay_emit) begin
      byte_q <= kind_char(rd_data_q);
      bv_q   <= 1'b1;
      fe_q   <= 1'b0;
      re_q   <= 1'b0;
      ov_q   <= 1'b0;
      last_q <= 1'b0;
    end
    if (cmd_in_i.final_emit) begin
      byte_q <= hold_q;
      bv_q   <= 1'b1;
      fe_q   <= 1'b0;
      re_q   <= 1'b0;
      ov_q   <= 1'b0;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = bv_q;
  assign field_end_o   = fe_q;
  assign record_end_o  = re_q;
  assign ws_overflow_o = ov_q;
  assign last_o        = last_q;

endmodule

// ===== design/csv_quoted_field_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// csv_quoted_field_splitter_unit
// Streaming CSV field splitter with quote handling and whitespace trimming.
// ----------------------------------------------------------------------------
// One line byte (or end-of-record) per input beat; each beat gives zero or
// more output beats: content bytes, or a field end marker on comma or end
// of record. Trailing whitespace inside a field is held in a buffer of
// MAX_PENDING_SPACES entries and replayed before the next non-space byte.
// A byte after held whitespace sends the block through a replay state, which
// emits the held bytes one entry per cycle while the output is free, then a
// final state that emits the byte; no new beat is taken until the results
// of the last one are in the output register. No clearing pass after reset.
module csv_quoted_field_splitter_unit
  import csvs_pkg::*;
#(
  parameter int MAX_PENDING_SPACES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       field_end_o,
  output logic       record_end_o,
  output logic       ws_overflow_o,
  output logic       last_o
);

  csvs_cmd_t cmd;
  csvs_sts_t sts;

  csvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csvs_dp #(
    .MaxPend (MAX_PENDING_SPACES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .data_byte_i   (data_byte_i),
    .cmd_in_i      (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .field_end_o   (field_end_o),
    .record_end_o  (record_end_o),
    .ws_overflow_o (ws_overflow_o),
    .last_o        (last_o)
  );

  a_fe_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_end_o |-> !byte_valid_o && last_o)
    else $error("field end carries a byte");

  a_re_is_fe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_end_o |-> field_end_o)
    else $error("record end without field end");

  a_ov_on_fe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ws_overflow_o |-> field_end_o)
    else $error("overflow flag off a field end");

  a_no_accept_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input taken while a replay is in progress");

endmodule
